// ----- design/utf8d_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and the national letter lookup for the decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	// configuration
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CODE_BASE    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INVALID_CODE = 2'd2;

	localparam logic [7:0] MAX_LENGTH_RESET   = 8'd20;
	localparam logic [7:0] CODE_BASE_RESET    = 8'd128;
	localparam logic [7:0] INVALID_CODE_RESET = 8'd127;

	// byte classes
	localparam logic [7:0] LEAD_MIN  = 8'h80;
	localparam logic [7:0] CONT_MASK = 8'h3f;
	localparam logic [7:0] LEAD_MASK = 8'h1f;

	// national letter table; only the first TABLE_ENTRIES are searched
	localparam int TABLE_ENTRIES  = 18;
	localparam int NATIONAL_COUNT = 18;
	localparam int SEARCH_COUNT   = (TABLE_ENTRIES < NATIONAL_COUNT) ?
		TABLE_ENTRIES : NATIONAL_COUNT;
	localparam int POINT_W = 11;

	localparam logic [POINT_W-1:0] NATIONAL_POINTS [NATIONAL_COUNT] = '{
		11'h104, 11'h105, 11'h106, 11'h107, 11'h118, 11'h119,
		11'h141, 11'h142, 11'h143, 11'h144, 11'h0d3, 11'h0f3,
		11'h15a, 11'h15b, 11'h179, 11'h17a, 11'h17b, 11'h17c
	};

	// front to back queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] max_length;
		logic [7:0] code_base;
		logic [7:0] invalid_code;
	} cfg_t;

	typedef enum logic [1:0] {
		KIND_ASCII,
		KIND_NATIONAL,
		KIND_TERM
	} item_kind_t;

	typedef struct packed {
		logic [7:0]         position;
		item_kind_t         kind;
		logic [POINT_W-1:0] value;
		logic               last;
	} queue_item_t;

	// first matching entry wins
	function automatic logic [7:0] national_code(
		input logic [POINT_W-1:0] point,
		input logic [7:0]         code_base,
		input logic [7:0]         invalid_code
	);
		logic [7:0] code;
		code = invalid_code;
		for (int i = SEARCH_COUNT - 1; i >= 0; i--) begin
			if (NATIONAL_POINTS[i] == point)
				code = code_base + 8'(i);
		end
		return code;
	endfunction

endpackage
`default_nettype wire

// ----- design/utf8d_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_in_if / utf8d_out_if
// Valid/ready channels for raw bytes in and decoded characters out.
// ----------------------------------------------------------------------------
interface utf8d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       start_of_string;

	modport source(output valid, output byte_in, output start_of_string, input ready);
	modport sink(input valid, input byte_in, input start_of_string, output ready);
endinterface

interface utf8d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] position;
	logic [7:0] char_code;
	logic       end_of_text;
	logic       last;

	modport source(output valid, output position, output char_code,
		output end_of_text, output last, input ready);
	modport sink(input valid, input position, input char_code,
		input end_of_text, input last, output ready);
endinterface
`default_nettype wire

// ----- design/utf8_national_char_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_national_char_decoder
// Two-byte UTF-8 decoder giving display codes and positions for a text line.
// ----------------------------------------------------------------------------
//
// channel   dir  fields                                       handshake
// byte_ch   in   byte_in[7:0], start_of_string                valid/ready
// char_ch   out  position[7:0], char_code[7:0], end_of_text,  valid/ready
//                last
// wr_*      in   wr_index[1:0], wr_data[7:0]                  wr_en, no wait
//
// One byte a cycle sustained while byte_ch.ready is high; a character word
// is written into the queue by its closing byte, then looked up into the output
// register. The 18 table compares run in parallel in the back stage.
// Reset clears string state and loads max_length 20, code_base 128,
// invalid_code 127; no clearing pass.
// byte_ch.ready drops only when the two-word queue is full, i.e. while the
// output word is stalled and two more words wait behind it.
// ----------------------------------------------------------------------------
module utf8_national_char_decoder import utf8d_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	utf8d_in_if.sink                    byte_ch,
	utf8d_out_if.source                 char_ch,
	input  wire logic                   wr_en,
	input  wire logic [CFG_INDEX_W-1:0] wr_index,
	input  wire logic [7:0]             wr_data
);

	cfg_t        cfg_q;

	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	queue_item_t q_item;
	queue_item_t q_head;

	// config registers; writes outside the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_length   <= MAX_LENGTH_RESET;
			cfg_q.code_base    <= CODE_BASE_RESET;
			cfg_q.invalid_code <= INVALID_CODE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_MAX_LENGTH:   cfg_q.max_length   <= wr_data;
				REG_CODE_BASE:    cfg_q.code_base    <= wr_data;
				REG_INVALID_CODE: cfg_q.invalid_code <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// front: byte acceptance and classification
	utf8d_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.byte_ch (byte_ch),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (q_item)
	);

	// decoupling queue
	utf8d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	// back: code lookup and output word register
	utf8d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.char_ch (char_ch)
	);

endmodule
`default_nettype wire

// ----- design/utf8d_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts bytes, tracks lead/position/end state and queues classified words.
// ----------------------------------------------------------------------------
module utf8d_front import utf8d_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	utf8d_in_if.sink         byte_ch,
	input  wire logic        q_full,
	output logic             q_push,
	output queue_item_t      q_item
);

	logic [4:0] lead_bits_q;
	logic       lead_pending_q;
	logic [7:0] char_position_q;
	logic       string_done_q;

	logic       accept;
	logic [7:0] pos;
	logic       pend;
	logic       done;
	logic       produce;
	logic       last;
	logic [8:0] pos_inc;
	logic [7:0] b;

	assign byte_ch.ready = !q_full;
	assign accept        = byte_ch.valid && byte_ch.ready;
	assign b             = byte_ch.byte_in;

	// start of string clears state ahead of the byte
	assign pos     = byte_ch.start_of_string ? 8'd0 : char_position_q;
	assign pend    = byte_ch.start_of_string ? 1'b0 : lead_pending_q;
	assign done    = byte_ch.start_of_string ? 1'b0 : string_done_q;
	assign pos_inc = {1'b0, pos} + 9'd1;
	assign last    = pos_inc >= {1'b0, cfg.max_length};

	always_comb begin
		produce         = 1'b0;
		q_item.position = pos;
		q_item.kind     = KIND_ASCII;
		q_item.value    = {3'd0, b};
		q_item.last     = 1'b0;
		if (!done && pos < cfg.max_length) begin
			if (pend) begin
				produce      = 1'b1;
				q_item.kind  = KIND_NATIONAL;
				q_item.value = {lead_bits_q, b[5:0] & CONT_MASK[5:0]};
				q_item.last  = last;
			end else if (b == 8'd0) begin
				produce     = 1'b1;
				q_item.kind = KIND_TERM;
			end else if (b < LEAD_MIN) begin
				produce     = 1'b1;
				q_item.last = last;
			end
		end
	end

	assign q_push = accept && produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_bits_q     <= '0;
			lead_pending_q  <= 1'b0;
			char_position_q <= '0;
			string_done_q   <= 1'b0;
		end else if (accept) begin
			lead_pending_q  <= pend;
			char_position_q <= pos;
			string_done_q   <= done;
			if (!done) begin
				if (pos >= cfg.max_length) begin
					string_done_q  <= 1'b1;
					lead_pending_q <= 1'b0;
				end else if (pend) begin
					lead_pending_q  <= 1'b0;
					char_position_q <= pos_inc[7:0];
					string_done_q   <= last;
				end else if (b == 8'd0) begin
					string_done_q <= 1'b1;
				end else if (b < LEAD_MIN) begin
					char_position_q <= pos_inc[7:0];
					string_done_q   <= last;
				end else begin
					lead_bits_q    <= b[4:0] & LEAD_MASK[4:0];
					lead_pending_q <= 1'b1;
				end
			end
		end
	end

	// after a terminator only a new string can queue another word
	a_term_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_item.kind == KIND_TERM) |=>
			!(q_push && !byte_ch.start_of_string))
		else $error("word queued after terminator without start of string");

endmodule
`default_nettype wire

// ----- design/utf8d_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_fifo
// Short register queue between front and back.
// ----------------------------------------------------------------------------
module utf8d_fifo import utf8d_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire queue_item_t push_item,
	input  wire logic        pop,
	output logic             full,
	output logic             empty,
	output queue_item_t      head
);

	queue_item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       count_q;

	assign full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ----- design/utf8d_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_back
// Maps queued words to display codes into the output register.
// ----------------------------------------------------------------------------
module utf8d_back import utf8d_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        q_empty,
	input  wire queue_item_t q_head,
	output logic             q_pop,
	utf8d_out_if.source      char_ch
);

	logic       valid_q;
	logic [7:0] position_q;
	logic [7:0] char_code_q;
	logic       end_of_text_q;
	logic       last_q;

	logic [7:0] code;
	logic       eot;

	always_comb begin
		case (q_head.kind)
			KIND_ASCII: begin
				code = q_head.value[7:0];
				eot  = 1'b0;
			end
			KIND_NATIONAL: begin
				code = national_code(q_head.value, cfg.code_base, cfg.invalid_code);
				eot  = 1'b0;
			end
			KIND_TERM: begin
				code = 8'd0;
				eot  = 1'b1;
			end
			default: begin
				code = cfg.invalid_code;
				eot  = 1'b0;
			end
		endcase
	end

	assign q_pop = !q_empty && (!valid_q || char_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (char_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			position_q    <= q_head.position;
			char_code_q   <= code;
			end_of_text_q <= eot;
			last_q        <= q_head.last && !eot;
		end
	end

	assign char_ch.valid       = valid_q;
	assign char_ch.position    = position_q;
	assign char_ch.char_code   = char_code_q;
	assign char_ch.end_of_text = end_of_text_q;
	assign char_ch.last        = last_q;

	a_term_word: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && end_of_text_q) |-> (char_code_q == 8'd0 && !last_q))
		else $error("terminator word with code or last flag");

endmodule
`default_nettype wire
